@@ rtl/rau_pkg.sv @@
// Package with item types, command codes and shared constants of the rational unit.
package rau_pkg;

	localparam int WIDTH = 32;
	localparam int MW = 64;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_NEG = 3'd4,
		CMD_RCP = 3'd5,
		CMD_EQ  = 3'd6,
		CMD_NOP = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic               is_equal;
		logic               div_zero;
		logic               overflow;
	} out_item_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		logic [2:0]  cmd;
		logic        early;
		out_item_t   early_res;
		logic        a_neg;
		logic [31:0] a_mag;
		logic [30:0] a_den;
		logic        b_neg;
		logic [31:0] b_mag;
		logic [30:0] b_den;
	} job_t;

endpackage

@@ rtl/rational_arith_unit_core.sv @@
// Top level of the rational arithmetic unit: front classifier, queue register, back sequencer.
//
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | in_item  (cmd, a_num, a_den, b_num, b_den)
//  output  | out_valid / out_ready| out_item (res_num, res_den, is_equal, div_zero, overflow)
//
// An item's path through the back sequencer depends on its command: binary gcds and
// restoring divisions share one datapath; add and subtract run two gcds and four divisions,
// multiply, divide, negate and reciprocal one and two, and an equality test neither.
// Trivial items (unused command, zero denominators, zero divisors) go from the front register
// straight to the output state, and an equality test does so once its products are formed.
// Reset clears the front valid flag and the sequencer state; payload is not reset.
// The front holds one classified item, so a new item is taken while the back works.
module rational_arith_unit_core
	import rau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic q_valid;
	logic q_ready;
	job_t q_job;

	// Front part classifies the item and holds it until the back part is free.
	rau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_job    (q_job)
	);

	// Back part computes and holds the result until it is taken.
	rau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_job     (q_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

@@ rtl/rau_front.sv @@
// Front part: takes items, splits signs from magnitudes and settles trivial cases.
module rau_front
	import rau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     q_valid,
	input  logic     q_ready,
	output job_t     q_job
);

	logic full_q;
	job_t job_q;
	job_t job_d;
	logic dz;

	assign in_ready = !full_q || q_ready;
	assign q_valid  = full_q;
	assign q_job    = job_q;

	always_comb begin
		job_d = '0;
		job_d.cmd   = in_item.cmd;
		job_d.a_neg = in_item.a_num[31];
		job_d.a_mag = in_item.a_num[31] ? 32'(-in_item.a_num) : in_item.a_num;
		job_d.a_den = in_item.a_den;
		job_d.b_neg = in_item.b_num[31];
		job_d.b_mag = in_item.b_num[31] ? 32'(-in_item.b_num) : in_item.b_num;
		job_d.b_den = in_item.b_den;
		dz = (in_item.a_den == '0)
			|| ((in_item.cmd <= CMD_DIV || in_item.cmd == CMD_EQ) && in_item.b_den == '0)
			|| (in_item.cmd == CMD_DIV && in_item.b_num == '0)
			|| (in_item.cmd == CMD_RCP && in_item.a_num == '0);
		if (in_item.cmd == CMD_NOP) begin
			job_d.early = 1'b1;
		end else if (dz) begin
			job_d.early = 1'b1;
			job_d.early_res.div_zero = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_q <= job_d;
		end
	end

endmodule

@@ rtl/rau_back.sv @@
// Back part: sequencer with one multiplier, a binary gcd and a restoring divider.
module rau_back
	import rau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  job_t      q_job,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_PREP, ST_GCD, ST_DIV, ST_AFTER, ST_FIN, ST_OUT
	} state_t;

	// Multiplication program steps.
	typedef enum logic [2:0] {
		PH_START, PH_L, PH_LA, PH_LB, PH_FORM
	} phase_t;

	state_t      state_q;
	phase_t      ph_q;
	job_t        job_q;
	logic        nneg_q;
	logic [63:0] nmag_q, den_q;
	logic [63:0] gx_q, gy_q;
	logic [6:0]  gsh_q;
	logic [63:0] g_q;
	logic [63:0] dvd_q, quo_q, rem_q;
	logic [6:0]  cnt_q;
	logic [1:0]  dsel_q;   // 0 and 3 lcm steps, 1 numerator, 2 denominator
	logic [63:0] l_q, la_q;
	logic        after_lcm_q;
	out_item_t   res_q;

	// Shared 32x32 multiplier operands.
	logic [31:0] mx, my;
	logic [63:0] prod;
	assign prod = 64'(mx) * 64'(my);

	logic [64:0] rtrial;
	assign rtrial = {rem_q, dvd_q[63]} - {1'b0, g_q};

	logic [63:0] limit;
	assign limit = 64'(1) << (WIDTH - 1);

	assign q_ready   = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_item  = res_q;

	always_comb begin
		mx = '0;
		my = '0;
		case (ph_q)
			PH_START: begin
				// add/subtract forms the lcm here as (ad/g)*bd
				mx = (job_q.cmd == CMD_ADD || job_q.cmd == CMD_SUB) ? l_q[31:0] : job_q.a_mag;
				my = (job_q.cmd == CMD_MUL) ? job_q.b_mag : 32'(job_q.b_den);
			end
			PH_L: begin
				mx = 32'(job_q.a_den);
				my = (job_q.cmd == CMD_MUL) ? 32'(job_q.b_den) : job_q.b_mag;
			end
			PH_LA: begin
				mx = la_q[31:0];
				my = job_q.a_mag;
			end
			PH_LB: begin
				mx = quo_q[31:0];
				my = job_q.b_mag;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PH_START;
		end else begin
			case (state_q)
				ST_IDLE: if (q_valid) begin
					job_q <= q_job;
					ph_q  <= PH_START;
					after_lcm_q <= 1'b0;
					res_q <= q_job.early_res;
					if (q_job.early) state_q <= ST_OUT;
					else state_q <= ST_MUL;
				end
				ST_MUL: begin
					case (job_q.cmd)
						CMD_MUL, CMD_DIV, CMD_EQ: begin
							if (ph_q == PH_START) begin
								nmag_q <= prod;
								ph_q   <= PH_L;
							end else begin
								nneg_q <= job_q.a_neg ^ job_q.b_neg;
								den_q  <= prod;
								if (job_q.cmd == CMD_EQ) begin
									res_q <= out_item_t'({63'd0, (nmag_q == prod) &&
										((job_q.a_neg && nmag_q != '0) ==
										 (job_q.b_neg && prod != '0)), 2'b00});
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_PREP;
								end
							end
						end
						CMD_NEG: begin
							nneg_q <= ~job_q.a_neg;
							nmag_q <= 64'(job_q.a_mag);
							den_q  <= 64'(job_q.a_den);
							state_q <= ST_PREP;
						end
						CMD_RCP: begin
							nneg_q <= job_q.a_neg;
							nmag_q <= 64'(job_q.a_den);
							den_q  <= 64'(job_q.a_mag);
							state_q <= ST_PREP;
						end
						default: begin
							// add/subtract: gcd of denominators first
							if (!after_lcm_q) begin
								nmag_q <= 64'(job_q.a_den);
								den_q  <= 64'(job_q.b_den);
								state_q <= ST_PREP;
							end else begin
								case (ph_q)
									PH_START: begin
										l_q  <= prod;     // lcm of the denominators
										ph_q <= PH_LA;
									end
									PH_LA: begin
										nmag_q <= prod;   // (l/ad)*|an|
										ph_q   <= PH_LB;
									end
									PH_LB: begin
										la_q <= prod;     // (l/bd)*|bn| stored
										ph_q <= PH_FORM;
									end
									default: begin
										// signed sum
										logic tn;
										tn = (job_q.cmd == CMD_SUB) ? ~job_q.b_neg : job_q.b_neg;
										if (la_q == '0) tn = 1'b0;
										if (job_q.a_neg == tn) begin
											nneg_q <= tn;
											nmag_q <= nmag_q + la_q;
										end else if (nmag_q >= la_q) begin
											nneg_q <= job_q.a_neg;
											nmag_q <= nmag_q - la_q;
										end else begin
											nneg_q <= tn;
											nmag_q <= la_q - nmag_q;
										end
										den_q  <= l_q;
										after_lcm_q <= 1'b0;
										state_q <= ST_PREP;
										dsel_q <= 2'd1;
									end
								endcase
							end
						end
					endcase
				end
				ST_PREP: begin
					if (den_q == '0) begin
						res_q <= out_item_t'({64'd0, 1'b1, 1'b0});
						state_q <= ST_OUT;
					end else begin
						gx_q  <= nmag_q;
						gy_q  <= den_q;
						gsh_q <= '0;
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					// binary gcd, one step per cycle
					if (gx_q == '0) begin
						g_q <= gy_q << gsh_q;
						state_q <= ST_DIV;
						cnt_q <= 7'd64;
						rem_q <= '0;
						if (after_lcm_q || dsel_q == 2'd0) begin
							dvd_q  <= 64'(job_q.a_den);
							dsel_q <= 2'd0;
						end else begin
							dvd_q  <= nmag_q;
							dsel_q <= 2'd1;
						end
					end else if (gy_q == '0) begin
						g_q <= gx_q << gsh_q;
						state_q <= ST_DIV;
						cnt_q <= 7'd64;
						rem_q <= '0;
						if (dsel_q == 2'd0) dvd_q <= 64'(job_q.a_den);
						else dvd_q <= nmag_q;
					end else if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; gsh_q <= gsh_q + 7'd1;
					end else if (!gx_q[0]) begin
						gx_q <= gx_q >> 1;
					end else if (!gy_q[0]) begin
						gy_q <= gy_q >> 1;
					end else if (gx_q >= gy_q) begin
						gx_q <= (gx_q - gy_q) >> 1;
					end else begin
						gy_q <= (gy_q - gx_q) >> 1;
					end
				end
				ST_DIV: begin
					// every quotient bit is shifted in anew, so no clear is needed
					if (cnt_q != '0) begin
						if (!rtrial[64]) begin
							rem_q <= rtrial[63:0];
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= {rem_q[62:0], dvd_q[63]};
							quo_q <= {quo_q[62:0], 1'b0};
						end
						dvd_q <= dvd_q << 1;
						cnt_q <= cnt_q - 7'd1;
					end else begin
						state_q <= ST_AFTER;
					end
				end
				ST_AFTER: begin
					case (dsel_q)
						2'd0: begin
							// quo = ad/g ; l = quo*bd ; then l/ad = bd/g, l/bd = quo
							la_q <= 64'(job_q.b_den);
							cnt_q <= 7'd64; rem_q <= '0; quo_q <= '0;
							dvd_q <= 64'(job_q.b_den);
							dsel_q <= 2'd3;
							l_q <= quo_q;   // ad/g
							state_q <= ST_DIV;
						end
						2'd3: begin
							// quo = bd/g = l/ad ; l_q holds ad/g = l/bd
							la_q  <= quo_q;
							quo_q <= l_q;
							after_lcm_q <= 1'b1;
							ph_q <= PH_START;
							state_q <= ST_MUL;
						end
						2'd1: begin
							nmag_q <= quo_q;
							cnt_q <= 7'd64; rem_q <= '0; quo_q <= '0;
							dvd_q <= den_q;
							dsel_q <= 2'd2;
							state_q <= ST_DIV;
						end
						default: begin
							den_q <= quo_q;
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_FIN: begin
					if (den_q > limit - 64'd1 ||
						nmag_q > ((nneg_q && nmag_q != '0) ? limit : limit - 64'd1)) begin
						res_q <= out_item_t'({65'd0, 1'b1});
					end else begin
						res_q <= out_item_t'({(nneg_q && nmag_q != '0) ? 32'(-nmag_q) :
							32'(nmag_q), 31'(den_q), 3'b000});
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_IDLE && q_valid) begin
				dsel_q <= (q_job.cmd == CMD_ADD || q_job.cmd == CMD_SUB) ? 2'd0 : 2'd1;
			end
		end
	end

endmodule

@@ tb/rational_arith_unit_core_test.sv @@
// Testbench for the rational arithmetic unit: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module rational_arith_unit_core_test
	import rau_pkg::*;
();

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// Expected results, oldest first, and the running failure state.
	out_item_t expected_results[$];
	bit        failed = 1'b0;
	bit        idle_on = 1'b1;
	longint    cycles = 0;

	localparam longint CYCLE_LIMIT = 3_000_000;

	rational_arith_unit_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Reduces a sign-magnitude fraction and packs it, flagging a zero denominator
	// or a reduced value that does not fit WIDTH bits.
	function automatic out_item_t reduce_fraction(bit neg, longint unsigned mag,
			longint unsigned den);
		out_item_t r;
		longint unsigned g, lim;
		r = '0;
		if (den == 0) begin
			r.div_zero = 1'b1;
			return r;
		end
		g = gcd64(mag, den);
		mag = mag / g;
		den = den / g;
		if (mag == 0)
			neg = 1'b0;
		lim = 64'd1 << (WIDTH - 1);
		if (den > lim - 1 || mag > (neg ? lim : lim - 1)) begin
			r.overflow = 1'b1;
			return r;
		end
		r.res_num = neg ? 32'(-mag) : 32'(mag);
		r.res_den = 31'(den);
		return r;
	endfunction

	// Works out the result of one item exactly, with 64-bit magnitudes.
	function automatic out_item_t rational_result(in_item_t it);
		out_item_t r;
		bit an, bn, tn, sn;
		longint unsigned am, bm, ad, bd, g, l, nm, tm, lm, rm;
		r = '0;
		an = it.a_num[31];
		bn = it.b_num[31];
		am = an ? 64'h1_0000_0000 - {32'd0, it.a_num} : {32'd0, it.a_num};
		bm = bn ? 64'h1_0000_0000 - {32'd0, it.b_num} : {32'd0, it.b_num};
		ad = {33'd0, it.a_den};
		bd = {33'd0, it.b_den};
		if (cmd_t'(it.cmd) == CMD_NOP)
			return r;
		if (ad == 0 || (it.cmd <= CMD_DIV && bd == 0) || (cmd_t'(it.cmd) == CMD_EQ && bd == 0)) begin
			r.div_zero = 1'b1;
			return r;
		end
		case (cmd_t'(it.cmd))
			CMD_ADD, CMD_SUB: begin
				g = gcd64(ad, bd);
				l = ad / g * bd;
				nm = (l / ad) * am;
				tm = (l / bd) * bm;
				tn = (cmd_t'(it.cmd) == CMD_SUB) ? !bn : bn;
				if (tm == 0)
					tn = 1'b0;
				if (an == tn) begin
					sn = an;
					nm = nm + tm;
				end else if (nm >= tm) begin
					sn = an;
					nm = nm - tm;
				end else begin
					sn = tn;
					nm = tm - nm;
				end
				r = reduce_fraction(sn, nm, l);
			end
			CMD_MUL: r = reduce_fraction(an != bn, am * bm, ad * bd);
			CMD_DIV: r = reduce_fraction(an != bn, am * bd, ad * bm);
			CMD_NEG: r = reduce_fraction(!an, am, ad);
			CMD_RCP: r = reduce_fraction(an, ad, am);
			default: begin
				lm = am * bd;
				rm = bm * ad;
				r.is_equal = (lm == rm) && ((an && lm != 0) == (bn && rm != 0));
			end
		endcase
		return r;
	endfunction

	// Sends one item, idling for a random burst first now and then. Valid stays
	// high from one item to the next unless an idle burst comes between them.
	task automatic send_item(cmd_t c, logic [31:0] an, logic [30:0] ad, logic [31:0] bn,
			logic [30:0] bd);
		in_item_t it;
		it = {c, an, ad, bn, bd};
		if (idle_on && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		expected_results.push_back(rational_result(it));
		do @(posedge clk); while (!in_ready);
	endtask

	// The receiver stalls in random bursts while idling is on.
	always @(posedge clk) begin
		if (idle_on && $urandom_range(4) == 0)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	// Compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: %h", out_item);
				failed = 1'b1;
			end else begin
				e = expected_results.pop_front();
				if (out_item.res_num !== e.res_num) begin
					$error("res_num expected %0d got %0d", e.res_num, out_item.res_num);
					failed = 1'b1;
				end
				if (out_item.res_den !== e.res_den) begin
					$error("res_den expected %0d got %0d", e.res_den, out_item.res_den);
					failed = 1'b1;
				end
				if (out_item.is_equal !== e.is_equal) begin
					$error("is_equal expected %b got %b", e.is_equal, out_item.is_equal);
					failed = 1'b1;
				end
				if (out_item.div_zero !== e.div_zero) begin
					$error("div_zero expected %b got %b", e.div_zero, out_item.div_zero);
					failed = 1'b1;
				end
				if (out_item.overflow !== e.overflow) begin
					$error("overflow expected %b got %b", e.overflow, out_item.overflow);
					failed = 1'b1;
				end
			end
		end
	end

	// A run that exceeds the cycle limit is a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL rational_arith_unit_core");
			$finish;
		end
	end

	// Directed items: extremes of the fields, every command and each special case.
	task automatic test_directed();
		cmd_t c;
		send_item(CMD_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
		send_item(CMD_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);              // zero result
		send_item(CMD_MUL, -32'sd3, 31'd4, 32'sd8, 31'd9);
		send_item(CMD_DIV, 32'sd3, 31'd4, -32'sd9, 31'd8);
		send_item(CMD_NEG, 32'h8000_0000, 31'd1, 32'sd0, 31'd1);        // negating the minimum
		send_item(CMD_NEG, 32'h8000_0000, 31'd2, 32'sd0, 31'd1);
		send_item(CMD_RCP, -32'sd7, 31'd3, 32'sd0, 31'd1);
		send_item(CMD_RCP, 32'sd0, 31'd3, 32'sd0, 31'd1);               // reciprocal of zero
		send_item(CMD_DIV, 32'sd5, 31'd3, 32'sd0, 31'd7);               // divide by zero value
		send_item(CMD_EQ, 32'sd2, 31'd4, 32'sd1, 31'd2);
		send_item(CMD_EQ, 32'sd0, 31'd4, 32'sd0, 31'd9);
		send_item(CMD_EQ, -32'sd1, 31'd2, 32'sd1, 31'd2);
		send_item(CMD_NOP, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
		// Zero input denominators for each command but the unused one.
		for (int k = 0; k < 7; k++) begin
			c = cmd_t'(k);
			send_item(c, 32'sd3, 31'd0, 32'sd5, 31'd7);
		end
		send_item(CMD_ADD, 32'sd3, 31'd5, 32'sd5, 31'd0);
		send_item(CMD_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1); // overflow
		send_item(CMD_MUL, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFE);
		send_item(CMD_SUB, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFE);
		send_item(CMD_ADD, 32'sd6, 31'd8, 32'sd10, 31'd4);             // unreduced inputs
	endtask

	// Random values biased toward small magnitudes so that most results fit.
	function automatic logic [31:0] random_num();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000)) - 1000);
			2: return 32'($signed($urandom_range(200000)) - 100000);
			default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		endcase
	endfunction

	function automatic logic [30:0] random_den();
		case ($urandom_range(9))
			0: return 31'd0;
			1: return 31'($urandom);
			2: return 31'h7FFF_FFFF;
			3, 4: return 31'($urandom_range(1, 100000));
			default: return 31'($urandom_range(1, 60));
		endcase
	endfunction

	task automatic test_random(int count);
		logic [31:0] an;
		for (int k = 0; k < count; k++) begin
			an = random_num();
			if ($urandom_range(9) == 0)
				send_item(cmd_t'($urandom_range(7)), an, random_den(), an, random_den());
			else
				send_item(cmd_t'($urandom_range(7)), an, random_den(), random_num(),
					random_den());
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1300);
		idle_on = 1'b0;
		test_random(330);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("PASS rational_arith_unit_core");
		else
			$display("FAIL rational_arith_unit_core");
		$finish;
	end

endmodule
